// ----- rtl/lmsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmsf_pkg
// Shared widths, reset values and control types of the adaptive fir filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsf_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 32;
	localparam int STEP_W   = 16;

	// register reset value, mu of about 0.3 in Q0.16
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd19661;

	// default filter length
	localparam int TAPS_DEFAULT = 16;

	// digit-serial multiplier: multiplier operand is consumed one digit a cycle
	localparam int DIGIT_W = 4;
	localparam int NDIG    = SAMPLE_W / DIGIT_W;
	localparam int CNT_W   = $clog2(NDIG);
	localparam int MCAND_W = 33;
	localparam int PROD_W  = MCAND_W + SAMPLE_W;

	// multiplier status
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	// word pushed into the circulating tap store
	typedef struct packed {
		logic                       rotate;
		logic signed [WEIGHT_W-1:0] w_push;
		logic signed [SAMPLE_W-1:0] h_push;
	} tap_push_t;

endpackage

`default_nettype wire

// ----- rtl/lmsf_if.sv -----
// ----------------------------------------------------------------------------
// lmsf_if
// Valid/ready channels for the sample words and the filter result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmsf_in_if ();
	logic                                valid;
	logic                                ready;
	logic signed [lmsf_pkg::SAMPLE_W-1:0] reference_sample;
	logic signed [lmsf_pkg::SAMPLE_W-1:0] error_sample;

	modport source (output valid, reference_sample, error_sample, input ready);
	modport sink   (input valid, reference_sample, error_sample, output ready);
endinterface

interface lmsf_out_if ();
	logic                                valid;
	logic                                ready;
	logic signed [lmsf_pkg::SAMPLE_W-1:0] filter_out;

	modport source (output valid, filter_out, input ready);
	modport sink   (input valid, filter_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/lmsf_digit_mul.sv -----
// ----------------------------------------------------------------------------
// lmsf_digit_mul
// Signed digit-serial multiplier, most significant digit first, one digit
// of the 16-bit multiplier per cycle into a shift-and-add accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_digit_mul (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [lmsf_pkg::MCAND_W-1:0]  mcand,
	input  wire logic signed [lmsf_pkg::SAMPLE_W-1:0] mplier,
	output lmsf_pkg::mul_stat_t                       stat,
	output logic signed [lmsf_pkg::PROD_W-1:0]        product
);

	localparam int PP_W = lmsf_pkg::MCAND_W + lmsf_pkg::DIGIT_W + 1;

	logic                                  busy_q;
	logic                                  done_q;
	logic [lmsf_pkg::CNT_W-1:0]            cnt_q;
	logic signed [lmsf_pkg::MCAND_W-1:0]   mcand_q;
	logic [lmsf_pkg::SAMPLE_W-1:0]         mplier_q;
	logic signed [lmsf_pkg::PROD_W-1:0]    acc_q;
	logic signed [lmsf_pkg::DIGIT_W:0]     digit;
	logic signed [PP_W-1:0]                pp;
	logic signed [lmsf_pkg::PROD_W-1:0]    acc_next;
	logic                                  last_digit;

	// top digit carries the sign, the rest are unsigned
	assign digit = {(cnt_q == '0) ? mplier_q[lmsf_pkg::SAMPLE_W-1] : 1'b0,
		mplier_q[lmsf_pkg::SAMPLE_W-1 -: lmsf_pkg::DIGIT_W]};
	assign pp = mcand_q * digit;
	assign acc_next = (acc_q <<< lmsf_pkg::DIGIT_W)
		+ {{(lmsf_pkg::PROD_W-PP_W){pp[PP_W-1]}}, pp};
	assign last_digit = (cnt_q == lmsf_pkg::CNT_W'(lmsf_pkg::NDIG - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_digit) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operand shift register and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			mplier_q <= mplier_q << lmsf_pkg::DIGIT_W;
			acc_q    <= acc_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

	// checks
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("multiplier done without a finished run");

endmodule

`default_nettype wire

// ----- rtl/lmsf_tap_store.sv -----
// ----------------------------------------------------------------------------
// lmsf_tap_store
// Circulating shift registers of tap weights and history samples; the head
// is read at slot 0 and each rotation pushes an updated word at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_tap_store #(
	parameter int TAPS = lmsf_pkg::TAPS_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire lmsf_pkg::tap_push_t                  push,
	output logic signed [lmsf_pkg::WEIGHT_W-1:0]      w_head,
	output logic signed [lmsf_pkg::SAMPLE_W-1:0]      h_head
);

	logic signed [lmsf_pkg::WEIGHT_W-1:0] w_q [TAPS];
	logic signed [lmsf_pkg::SAMPLE_W-1:0] h_q [TAPS];

	// rotate toward the head, new word enters at the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				w_q[i] <= '0;
				h_q[i] <= '0;
			end
		end else if (push.rotate) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				w_q[i] <= w_q[i+1];
				h_q[i] <= h_q[i+1];
			end
			w_q[TAPS-1] <= push.w_push;
			h_q[TAPS-1] <= push.h_push;
		end
	end

	assign w_head = w_q[0];
	assign h_head = h_q[0];

endmodule

`default_nettype wire

// ----- rtl/lms_adaptive_fir_filter.sv -----
// ----------------------------------------------------------------------------
// lms_adaptive_fir_filter
// LMS adaptive FIR filter built around one shared digit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  samples : words of reference_sample and error_sample (Q1.15), taken on
//            valid && ready. ready is high only while no word is in work.
//  results : one filter_out word (Q1.15, saturated) per sample word, held in
//            an output register until the receiver takes it.
//  cfg_we / cfg_wdata : write of step_size (Q0.16), only while idle.
// Each word first adapts every weight by mu * error * old history, then
// shifts the new sample in and forms the rounded dot product.
// Between acceptance and result valid the multiplier forms 2 * TAPS + 1
// products in turn: mu * error, then per tap the weight update and the
// filter product; the result is then loaded into the output register.
// A new word is taken only once the last one is loaded; ready comes back in
// the cycle after the result is loaded.
// A result that is not taken does not stop the next word from being
// accepted; only its own result waits for the output register to free up.
// Reset clears weights and history to zero, step_size to 19661 and drops
// any word in work.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_adaptive_fir_filter #(
	parameter int TAPS = lmsf_pkg::TAPS_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lmsf_pkg::STEP_W-1:0]        cfg_wdata,
	lmsf_in_if.sink                                 samples,
	lmsf_out_if.source                              results
);

	localparam int TAP_W = $clog2(TAPS);
	localparam int ACC_W = lmsf_pkg::WEIGHT_W + lmsf_pkg::SAMPLE_W + $clog2(TAPS);
	localparam int Y_W   = ACC_W - 27;
	localparam int SW    = lmsf_pkg::SAMPLE_W;
	localparam int WW    = lmsf_pkg::WEIGHT_W;
	localparam int PW    = lmsf_pkg::PROD_W;
	localparam int MW    = lmsf_pkg::MCAND_W;

	// sequencer codes
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EM_GO    = 3'd1;
	localparam logic [2:0] ST_EM_WAIT  = 3'd2;
	localparam logic [2:0] ST_UPD_GO   = 3'd3;
	localparam logic [2:0] ST_UPD_WAIT = 3'd4;
	localparam logic [2:0] ST_FIR_GO   = 3'd5;
	localparam logic [2:0] ST_FIR_WAIT = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	logic [2:0]                  state_q;
	logic [lmsf_pkg::STEP_W-1:0] step_q;
	logic [TAP_W-1:0]            tap_q;
	logic                        out_valid_q;
	logic signed [SW-1:0]        out_data_q;
	logic signed [SW-1:0]        x_q;
	logic signed [SW-1:0]        err_q;
	logic signed [SW-1:0]        prev_q;
	logic signed [WW-1:0]        em_q;
	logic signed [WW-1:0]        w_new_q;
	logic signed [ACC_W-1:0]     acc_q;

	logic                        accept;
	logic                        out_load;
	logic                        mul_start;
	logic signed [MW-1:0]        mul_mcand;
	logic signed [SW-1:0]        mul_mplier;
	lmsf_pkg::mul_stat_t         mul_stat;
	logic signed [PW-1:0]        product;
	lmsf_pkg::tap_push_t         push;
	logic signed [WW-1:0]        w_head;
	logic signed [SW-1:0]        h_head;
	logic signed [SW-1:0]        h_new;
	logic signed [WW-1:0]        w_upd;
	logic signed [SW-1:0]        y_sat;
	logic                        last_tap;

	// weight update: round Q2.46 term to Q5.27, saturating add
	function automatic logic signed [WW-1:0] upd_weight(
		input logic signed [WW-1:0] w,
		input logic signed [PW-1:0] p
	);
		logic signed [PW-1:0] t;
		logic signed [WW:0]   s;
		t = p + PW'(1 << 18);
		s = {w[WW-1], w} + {{(WW + 1 - (PW - 19)){t[PW-1]}}, t[PW-1:19]};
		if (s[WW] != s[WW-1])
			upd_weight = s[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
		else
			upd_weight = s[WW-1:0];
	endfunction

	assign accept   = samples.valid && samples.ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || results.ready);
	assign last_tap = (tap_q == TAP_W'(TAPS - 1));
	assign h_new    = (tap_q == '0) ? x_q : prev_q;
	assign w_upd    = upd_weight(w_head, product);

	// output rounding and saturation to Q1.15
	always_comb begin
		logic signed [ACC_W-1:0] t;
		logic signed [Y_W-1:0]   y;
		t = acc_q + ACC_W'(1 << 26);
		y = t[ACC_W-1:27];
		if (!y[Y_W-1] && (|y[Y_W-2:SW-1]))
			y_sat = {1'b0, {(SW-1){1'b1}}};
		else if (y[Y_W-1] && !(&y[Y_W-2:SW-1]))
			y_sat = {1'b1, {(SW-1){1'b0}}};
		else
			y_sat = y[SW-1:0];
	end

	// multiplier operand select
	always_comb begin
		mul_start  = 1'b0;
		mul_mcand  = {{(MW - lmsf_pkg::STEP_W){1'b0}}, step_q};
		mul_mplier = err_q;
		case (state_q)
			ST_EM_GO: begin
				mul_start = 1'b1;
			end
			ST_UPD_GO: begin
				mul_start  = 1'b1;
				mul_mcand  = {{(MW - WW){em_q[WW-1]}}, em_q};
				mul_mplier = h_head;
			end
			ST_FIR_GO: begin
				mul_start  = 1'b1;
				mul_mcand  = {{(MW - WW){w_new_q[WW-1]}}, w_new_q};
				mul_mplier = h_new;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// rotate the store once a tap is finished
	always_comb begin
		push.rotate = (state_q == ST_FIR_WAIT) && mul_stat.done;
		push.w_push = w_new_q;
		push.h_push = h_new;
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= lmsf_pkg::STEP_RESET;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				step_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EM_GO;
				end
				ST_EM_GO: begin
					state_q <= ST_EM_WAIT;
				end
				ST_EM_WAIT: begin
					if (mul_stat.done) begin
						tap_q   <= '0;
						state_q <= ST_UPD_GO;
					end
				end
				ST_UPD_GO: begin
					state_q <= ST_UPD_WAIT;
				end
				ST_UPD_WAIT: begin
					if (mul_stat.done)
						state_q <= ST_FIR_GO;
				end
				ST_FIR_GO: begin
					state_q <= ST_FIR_WAIT;
				end
				ST_FIR_WAIT: begin
					if (mul_stat.done) begin
						if (last_tap) begin
							state_q <= ST_DONE;
						end else begin
							tap_q   <= tap_q + 1'b1;
							state_q <= ST_UPD_GO;
						end
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= samples.reference_sample;
			err_q <= samples.error_sample;
		end
		if ((state_q == ST_EM_WAIT) && mul_stat.done) begin
			em_q  <= product[WW-1:0];
			acc_q <= '0;
		end
		if ((state_q == ST_UPD_WAIT) && mul_stat.done)
			w_new_q <= w_upd;
		if (push.rotate) begin
			acc_q  <= acc_q + {{(ACC_W - (PW - 1)){product[PW-2]}}, product[PW-2:0]};
			prev_q <= h_head;
		end
		if (out_load)
			out_data_q <= y_sat;
	end

	lmsf_digit_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.stat    (mul_stat),
		.product (product)
	);

	lmsf_tap_store #(
		.TAPS (TAPS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.w_head (w_head),
		.h_head (h_head)
	);

	assign samples.ready    = (state_q == ST_IDLE);
	assign results.valid    = out_valid_q;
	assign results.filter_out = out_data_q;

	// checks
	a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!mul_stat.busy && !mul_stat.done))
		else $error("multiplier active while idle");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> ((state_q == ST_EM_WAIT) || (state_q == ST_UPD_WAIT)
			|| (state_q == ST_FIR_WAIT)))
		else $error("multiplier result outside a wait state");

endmodule

`default_nettype wire

// ----- tb/sv/tb_lms_adaptive_fir_filter.sv -----
// ----------------------------------------------------------------------------
// tb_lms_adaptive_fir_filter
// Self-checking bench for the lms adaptive fir filter. Sample words go in with
// random gaps and the result side stalls at random. A bit-exact tracker of the
// weights, the history and the step size predicts every filter_out word, and
// each taken result word is compared with the oldest prediction. The step size
// changes between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lms_adaptive_fir_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPS    = lmsf_pkg::TAPS_DEFAULT;
	localparam int LATENCY = 12 * TAPS + 7;

	localparam longint WEIGHT_MAX = 64'sd2147483647;
	localparam longint WEIGHT_MIN = -64'sd2147483648;
	localparam longint DRIVE_MAX  = 64'sd32767;
	localparam longint DRIVE_MIN  = -64'sd32768;

	// tracks weights and history and holds the filter_out words still owed
	class filter_tracker;
		logic [lmsf_pkg::STEP_W-1:0]          mu;
		logic signed [lmsf_pkg::WEIGHT_W-1:0] weights [TAPS];
		logic signed [lmsf_pkg::SAMPLE_W-1:0] history [TAPS];
		logic signed [lmsf_pkg::SAMPLE_W-1:0] expected_drive [$];
		int                                   words_out;
		int                                   mismatches;

		function new();
			mu = lmsf_pkg::STEP_RESET;
			foreach (weights[i]) begin
				weights[i] = '0;
				history[i] = '0;
			end
			words_out  = 0;
			mismatches = 0;
		endfunction

		function void set_step(logic [lmsf_pkg::STEP_W-1:0] v);
			mu = v;
		endfunction

		// adapt with the old history, shift the sample in, then filter
		function void note_sample(logic signed [lmsf_pkg::SAMPLE_W-1:0] x,
				logic signed [lmsf_pkg::SAMPLE_W-1:0] e);
			longint rate;
			longint term;
			longint w;
			longint acc;
			longint y;
			rate = mu;
			acc  = 0;
			for (int i = 0; i < TAPS; i++) begin
				term = longint'(history[i]) * longint'(e) * rate;
				term = (term + (longint'(1) <<< 18)) >>> 19;
				w = longint'(weights[i]) + term;
				if (w > WEIGHT_MAX)
					w = WEIGHT_MAX;
				if (w < WEIGHT_MIN)
					w = WEIGHT_MIN;
				weights[i] = w[lmsf_pkg::WEIGHT_W-1:0];
			end
			for (int i = TAPS - 1; i > 0; i--)
				history[i] = history[i-1];
			history[0] = x;
			for (int i = 0; i < TAPS; i++)
				acc += longint'(weights[i]) * longint'(history[i]);
			y = (acc + (longint'(1) <<< 26)) >>> 27;
			if (y > DRIVE_MAX)
				y = DRIVE_MAX;
			if (y < DRIVE_MIN)
				y = DRIVE_MIN;
			expected_drive.push_back(y[lmsf_pkg::SAMPLE_W-1:0]);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_drive(logic signed [lmsf_pkg::SAMPLE_W-1:0] got);
			logic signed [lmsf_pkg::SAMPLE_W-1:0] want;
			if (expected_drive.size() == 0) begin
				report($sformatf("filter_out %0d with no sample word waiting", got));
			end else begin
				want = expected_drive.pop_front();
				if (got !== want)
					report($sformatf("word %0d filter_out got %0d expected %0d",
						words_out, got, want));
			end
			words_out++;
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [lmsf_pkg::STEP_W-1:0] cfg_wdata;
	bit                          idle_on;
	int                          rx_hold;
	filter_tracker               tracker;

	lmsf_in_if  samples_if ();
	lmsf_out_if results_if ();

	lms_adaptive_fir_filter #(
		.TAPS(TAPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples(samples_if),
		.results(results_if)
	);

	// clock
	always #5 clk = ~clk;

	// receiver with random stall bursts
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			results_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rx_hold <= $urandom_range(0, 11);
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	// check every result word taken
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			tracker.check_drive(results_if.filter_out);
	end

	// one sample word, with an optional gap before it
	task automatic send_word(logic [lmsf_pkg::SAMPLE_W-1:0] x,
			logic [lmsf_pkg::SAMPLE_W-1:0] e);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		samples_if.valid            <= 1'b1;
		samples_if.reference_sample <= x;
		samples_if.error_sample     <= e;
		do @(posedge clk); while (!samples_if.ready);
		tracker.note_sample(x, e);
	endtask

	// wait until every owed result word has been taken
	task automatic drain();
		do @(posedge clk); while (tracker.expected_drive.size() != 0);
	endtask

	// new step size, only once the block has gone idle
	task automatic write_step(logic [lmsf_pkg::STEP_W-1:0] v);
		samples_if.valid <= 1'b0;
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		tracker.set_step(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [lmsf_pkg::SAMPLE_W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'h0001;
			4:       return 16'hffff;
			default: return 16'h8001;
		endcase
	endfunction

	// large magnitude of a fixed sign, slightly jittered
	function automatic logic [lmsf_pkg::SAMPLE_W-1:0] near_full(bit neg);
		if (neg)
			return 16'(16'h8000 + $urandom_range(0, 255));
		return 16'(16'h7fff - $urandom_range(0, 255));
	endfunction

	// mix of random words, extremes, tiny errors and same-sign runs
	task automatic random_phase(int n_words);
		int sent;
		int burst;
		int mode;
		bit xneg;
		bit eneg;
		sent = 0;
		while (sent < n_words) begin
			mode = $urandom_range(0, 9);
			if (mode < 5) begin
				send_word(16'($urandom), 16'($urandom));
				sent++;
			end else if (mode < 7) begin
				send_word(pick_extreme(), pick_extreme());
				sent++;
			end else if (mode < 8) begin
				send_word(16'($urandom), 16'(int'($urandom_range(0, 8)) - 4));
				sent++;
			end else begin
				// same-sign run pushes weights and output into saturation
				burst = $urandom_range(10, 30);
				if (burst > n_words - sent)
					burst = n_words - sent;
				xneg  = 1'($urandom);
				eneg  = 1'($urandom);
				repeat (burst) send_word(near_full(xneg), near_full(eneg));
				sent += burst;
			end
		end
	endtask

	// main sequence
	initial begin
		tracker                     = new();
		arst_n                      = 1'b0;
		cfg_we                      = 1'b0;
		cfg_wdata                   = '0;
		idle_on                     = 1'b0;
		samples_if.valid            = 1'b0;
		samples_if.reference_sample = '0;
		samples_if.error_sample     = '0;
		results_if.ready            = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes at the reset step size
		send_word(16'h0000, 16'h0000);
		send_word(16'h7fff, 16'h0000);
		send_word(16'h8000, 16'h0000);
		send_word(16'h0001, 16'hffff);
		send_word(16'hffff, 16'h7fff);
		send_word(16'h7fff, 16'h8000);

		// largest step, full-scale words fill and push the oldest slot out
		write_step(16'hffff);
		repeat (14) send_word(16'h8000, 16'h8000);
		repeat (4) send_word(16'h7fff, 16'h7fff);

		// random phases over several step sizes
		idle_on = 1'b1;
		random_phase(90);
		write_step(16'h0000);
		random_phase(90);
		idle_on = 1'b0;
		write_step(16'h0001);
		random_phase(90);
		idle_on = 1'b1;
		write_step(lmsf_pkg::STEP_RESET);
		random_phase(90);
		write_step(16'($urandom));
		random_phase(90);
		write_step(16'h8000);
		random_phase(90);
		idle_on = 1'b0;
		write_step(16'($urandom));
		random_phase(90);

		samples_if.valid <= 1'b0;
		drain();
		repeat (LATENCY + 50) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_drive.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hang guard
	initial begin
		#8_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
